// ----- design/per_client_ewma_rate_meter_unit_defines.svh -----
// Assertion macros for the per-client EWMA rate meter.
`ifndef PER_CLIENT_EWMA_RATE_METER_UNIT_DEFINES_SVH
`define PER_CLIENT_EWMA_RATE_METER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PCER_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds after ante rather than in the same cycle.
`define PCER_ASSERT_LATER2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// ----- design/pcer_pkg.sv -----
// Package: constants, types and state codes of the per-client EWMA rate meter.
`default_nettype none
package pcer_pkg;

  localparam int CLIENT_ENTRIES = 64;
  localparam int ENTRY_W        = $clog2(CLIENT_ENTRIES);

  localparam int CLIENT_W   = 6;
  localparam int TOTAL_W    = 63;
  localparam int INTERVAL_W = 32;
  localparam int AVG_W      = 40;
  localparam int GAIN_W     = 17;
  localparam int RATE_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam int QUO_W     = 42;
  localparam int LOW_W     = QUO_W - 8;
  localparam int WORK_W    = TOTAL_W + 10;
  localparam int HI_W      = WORK_W - LOW_W;
  localparam int DIV_STEPS = QUO_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int PROD_W    = AVG_W + GAIN_W;
  localparam int ACC_W     = PROD_W + 1;

  localparam logic [GAIN_W-1:0]     GAIN_ONE       = 17'h10000;
  localparam logic [GAIN_W-1:0]     GAIN_RESET     = 17'd19661;
  localparam logic [RATE_W-1:0]     MAX_RATE_RESET = 32'd125000000;
  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL   = 32'd1000;
  localparam logic [ACC_W-1:0]      ROUND_HALF     = 58'd32768;

  localparam logic OP_UPDATE  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_GAIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE       = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DELTA,
    ST_MUL1,
    ST_MUL2,
    ST_DINIT,
    ST_DIV,
    ST_CLAMP,
    ST_SM1,
    ST_SM2
  } state_e;

  typedef struct packed {
    logic [TOTAL_W-1:0] last_rx;
    logic [TOTAL_W-1:0] last_tx;
    logic [AVG_W-1:0]   rx_avg;
    logic [AVG_W-1:0]   tx_avg;
  } entry_t;

endpackage
`default_nettype wire

// ----- design/per_client_ewma_rate_meter_unit.sv -----
// Top level: per-client EWMA rate meter with entry table and shared divide/multiply datapath.
// An update of a known entry with nonzero interval goes from accept to done strobe through
// two passes (rx, then tx) of a 2-bit-per-cycle divider (21 steps) and a shared multiplier.
// Release, zero interval and first update give done through ST_DECIDE; an index beyond the table
// gives done in the cycle after accept. busy_o is high until the done cycle; the receiver cannot stall.
// Reset clears all entry valid bits at once and loads register reset values; no clearing pass.
`default_nettype none
module per_client_ewma_rate_meter_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic                              op_i,
  input  wire logic [pcer_pkg::CLIENT_W-1:0]     client_index_i,
  input  wire logic [pcer_pkg::TOTAL_W-1:0]      rx_total_i,
  input  wire logic [pcer_pkg::TOTAL_W-1:0]      tx_total_i,
  input  wire logic [pcer_pkg::INTERVAL_W-1:0]   interval_ms_i,
  output logic                                   done_o,
  output logic      [pcer_pkg::AVG_W-1:0]        avg_rx_rate_o,
  output logic      [pcer_pkg::AVG_W-1:0]        avg_tx_rate_o,
  output logic                                   entry_known_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [pcer_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [pcer_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import pcer_pkg::*;

  state_e state_q, state_d;

  logic [GAIN_W-1:0] gain_q;
  logic [RATE_W-1:0] max_rate_q;

  logic valid_q [CLIENT_ENTRIES];
  logic valid_set, valid_clr;

  logic                  op_q, op_d;
  logic [ENTRY_W-1:0]    idx_q, idx_d;
  logic [TOTAL_W-1:0]    rx_q, rx_d, tx_q, tx_d;
  logic                  zero_int_q, zero_int_d;
  logic [INTERVAL_W-1:0] div_q, div_d;
  logic                  known_q, known_d;
  logic                  chan_q, chan_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [TOTAL_W-1:0]    delta_q, delta_d;
  logic [WORK_W-1:0]     work_q, work_d;
  logic                  sat_q, sat_d;
  logic [INTERVAL_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]      dvd_q, dvd_d, quo_q, quo_d;
  logic [AVG_W-1:0]      inst_q, inst_d;
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [AVG_W-1:0]      new_rx_q, new_rx_d;

  logic                  done_q, done_d;
  logic [AVG_W-1:0]      out_rx_q, out_rx_d, out_tx_q, out_tx_d;
  logic                  out_known_q, out_known_d;

  logic                  ram_we;
  entry_t                ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0]    ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rbits;

  logic                  accept_c, in_range_c;
  logic [ENTRY_W-1:0]    addr_in_c;
  logic [GAIN_W-1:0]     g_c, w_c;
  logic [AVG_W-1:0]      mul_a;
  logic [GAIN_W-1:0]     mul_b;
  logic [PROD_W-1:0]     mul_p;
  logic [ACC_W-1:0]      acc_sum;
  logic [TOTAL_W:0]      diff_c;
  logic [HI_W-1:0]       hi_c;
  logic [INTERVAL_W:0]   r1_c, r2_c, r1s_c, r2s_c;
  logic                  ge1_c, ge2_c;
  logic [AVG_W-1:0]      cap_c;

  assign busy_o     = (state_q != ST_IDLE);
  assign accept_c   = start_i && !busy_o;
  assign in_range_c = int'(client_index_i) < CLIENT_ENTRIES;
  assign addr_in_c  = ENTRY_W'(client_index_i);
  assign ram_raddr  = busy_o ? idx_q : addr_in_c;
  assign ram_rdata  = entry_t'(ram_rbits);

  assign g_c   = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;
  assign w_c   = GAIN_ONE - g_c;
  assign cap_c = {max_rate_q, 8'b0};
  assign mul_p = mul_a * mul_b;

  pcer_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CLIENT_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rbits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= GAIN_RESET;
      max_rate_q <= MAX_RATE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SMOOTHING_GAIN: gain_q     <= cfg_wdata_i[GAIN_W-1:0];
        CFG_MAX_RATE:       max_rate_q <= cfg_wdata_i[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CLIENT_ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (valid_clr) begin
      valid_q[idx_q] <= 1'b0;
    end else if (valid_set) begin
      valid_q[idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      chan_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      chan_q  <= chan_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    idx_q       <= idx_d;
    rx_q        <= rx_d;
    tx_q        <= tx_d;
    zero_int_q  <= zero_int_d;
    div_q       <= div_d;
    known_q     <= known_d;
    delta_q     <= delta_d;
    work_q      <= work_d;
    sat_q       <= sat_d;
    rem_q       <= rem_d;
    dvd_q       <= dvd_d;
    quo_q       <= quo_d;
    inst_q      <= inst_d;
    acc_q       <= acc_d;
    new_rx_q    <= new_rx_d;
    out_rx_q    <= out_rx_d;
    out_tx_q    <= out_tx_d;
    out_known_q <= out_known_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    rx_d        = rx_q;
    tx_d        = tx_q;
    zero_int_d  = zero_int_q;
    div_d       = div_q;
    known_d     = known_q;
    chan_d      = chan_q;
    step_d      = step_q;
    delta_d     = delta_q;
    work_d      = work_q;
    sat_d       = sat_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    inst_d      = inst_q;
    acc_d       = acc_q;
    new_rx_d    = new_rx_q;
    done_d      = 1'b0;
    out_rx_d    = out_rx_q;
    out_tx_d    = out_tx_q;
    out_known_d = out_known_q;
    valid_set   = 1'b0;
    valid_clr   = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = '{last_rx: rx_q, last_tx: tx_q, rx_avg: new_rx_q, tx_avg: '0};
    mul_a       = chan_q ? ram_rdata.tx_avg : ram_rdata.rx_avg;
    mul_b       = w_c;
    acc_sum     = acc_q + ACC_W'(mul_p) + ROUND_HALF;

    diff_c = {1'b0, (chan_q ? tx_q : rx_q)}
           - {1'b0, (chan_q ? ram_rdata.last_tx : ram_rdata.last_rx)};
    hi_c   = work_q[WORK_W-1:LOW_W];
    r1_c   = {rem_q, dvd_q[QUO_W-1]};
    ge1_c  = r1_c >= {1'b0, div_q};
    r1s_c  = ge1_c ? (r1_c - {1'b0, div_q}) : r1_c;
    r2_c   = {r1s_c[INTERVAL_W-1:0], dvd_q[QUO_W-2]};
    ge2_c  = r2_c >= {1'b0, div_q};
    r2s_c  = ge2_c ? (r2_c - {1'b0, div_q}) : r2_c;

    case (state_q)
      ST_IDLE: begin
        if (accept_c) begin
          op_d       = op_i;
          idx_d      = addr_in_c;
          rx_d       = rx_total_i;
          tx_d       = tx_total_i;
          zero_int_d = (interval_ms_i == '0);
          div_d      = (interval_ms_i < MIN_INTERVAL) ? MIN_INTERVAL : interval_ms_i;
          if (in_range_c) begin
            known_d = valid_q[addr_in_c];
            state_d = ST_DECIDE;
          end else begin
            done_d      = 1'b1;
            out_rx_d    = '0;
            out_tx_d    = '0;
            out_known_d = 1'b0;
          end
        end
      end
      ST_DECIDE: begin
        out_known_d = known_q;
        out_rx_d    = '0;
        out_tx_d    = '0;
        if (op_q == OP_RELEASE) begin
          valid_clr = 1'b1;
          done_d    = 1'b1;
          state_d   = ST_IDLE;
        end else if (zero_int_q) begin
          if (known_q) begin
            out_rx_d = ram_rdata.rx_avg;
            out_tx_d = ram_rdata.tx_avg;
          end
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (!known_q) begin
          ram_we    = 1'b1;
          ram_wdata = '{last_rx: rx_q, last_tx: tx_q, rx_avg: '0, tx_avg: '0};
          valid_set = 1'b1;
          done_d    = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          chan_d  = 1'b0;
          state_d = ST_DELTA;
        end
      end
      ST_DELTA: begin
        delta_d = diff_c[TOTAL_W] ? '0 : diff_c[TOTAL_W-1:0];
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        work_d  = WORK_W'({delta_q, 4'b0}) + WORK_W'({delta_q, 3'b0});
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        work_d  = {delta_q, 10'b0} - work_q;
        state_d = ST_DINIT;
      end
      ST_DINIT: begin
        sat_d   = hi_c >= HI_W'(div_q);
        rem_d   = hi_c[INTERVAL_W-1:0];
        dvd_d   = {work_q[LOW_W-1:0], 8'b0};
        quo_d   = '0;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = r2s_c[INTERVAL_W-1:0];
        dvd_d = {dvd_q[QUO_W-3:0], 2'b0};
        quo_d = {quo_q[QUO_W-3:0], ge1_c, ge2_c};
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_CLAMP;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_CLAMP: begin
        if (sat_q || (quo_q > QUO_W'(cap_c))) begin
          inst_d = cap_c;
        end else begin
          inst_d = quo_q[AVG_W-1:0];
        end
        state_d = ST_SM1;
      end
      ST_SM1: begin
        acc_d   = ACC_W'(mul_p);
        state_d = ST_SM2;
      end
      ST_SM2: begin
        mul_a   = inst_q;
        mul_b   = g_c;
        acc_sum = acc_q + ACC_W'(mul_p) + ROUND_HALF;
        if (!chan_q) begin
          new_rx_d = acc_sum[16 +: AVG_W];
          chan_d   = 1'b1;
          state_d  = ST_DELTA;
        end else begin
          ram_we      = 1'b1;
          ram_wdata   = '{last_rx: rx_q, last_tx: tx_q, rx_avg: new_rx_q,
                          tx_avg: acc_sum[16 +: AVG_W]};
          out_rx_d    = new_rx_q;
          out_tx_d    = acc_sum[16 +: AVG_W];
          out_known_d = 1'b1;
          done_d      = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign done_o        = done_q;
  assign avg_rx_rate_o = out_rx_q;
  assign avg_tx_rate_o = out_tx_q;
  assign entry_known_o = out_known_q;

`include "per_client_ewma_rate_meter_unit_defines.svh"

  `PCER_ASSERT_NOW(a_done_follows_work, done_o, $past(busy_o || start_i), "done without a word in work")
  `PCER_ASSERT_LATER2(a_release_zero, start_i && !busy_o && op_i == OP_RELEASE && in_range_c, done_o && avg_rx_rate_o == '0 && avg_tx_rate_o == '0, "release result not zero")
  `PCER_ASSERT_NOW(a_avg_needs_known, done_o && (avg_rx_rate_o != '0 || avg_tx_rate_o != '0), entry_known_o, "nonzero average on unknown entry")

endmodule
`default_nettype wire

// ----- design/pcer_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pcer_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the per-client EWMA rate meter: queued stimulus and scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcer_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PRINT_CAP    = 50;
  localparam int RANDOM_WORDS = 96;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef struct {
    logic                  op;
    logic [CLIENT_W-1:0]   client;
    logic [TOTAL_W-1:0]    rx_total;
    logic [TOTAL_W-1:0]    tx_total;
    logic [INTERVAL_W-1:0] interval_ms;
  } meter_cmd_t;

  typedef struct {
    logic [AVG_W-1:0] rx_avg;
    logic [AVG_W-1:0] tx_avg;
    logic             known;
  } meter_reading_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  start_i        = 1'b0;
  logic                  op_i           = OP_UPDATE;
  logic [CLIENT_W-1:0]   client_index_i = '0;
  logic [TOTAL_W-1:0]    rx_total_i     = '0;
  logic [TOTAL_W-1:0]    tx_total_i     = '0;
  logic [INTERVAL_W-1:0] interval_ms_i  = '0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = CFG_SMOOTHING_GAIN;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  busy_o;
  logic                  done_o;
  logic [AVG_W-1:0]      avg_rx_rate_o;
  logic [AVG_W-1:0]      avg_tx_rate_o;
  logic                  entry_known_o;

  per_client_ewma_rate_meter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .client_index_i (client_index_i),
    .rx_total_i     (rx_total_i),
    .tx_total_i     (tx_total_i),
    .interval_ms_i  (interval_ms_i),
    .done_o         (done_o),
    .avg_rx_rate_o  (avg_rx_rate_o),
    .avg_tx_rate_o  (avg_tx_rate_o),
    .entry_known_o  (entry_known_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  logic                 meter_valid   [CLIENT_ENTRIES];
  logic [TOTAL_W-1:0]   meter_last_rx [CLIENT_ENTRIES];
  logic [TOTAL_W-1:0]   meter_last_tx [CLIENT_ENTRIES];
  logic [AVG_W-1:0]     meter_rx_avg  [CLIENT_ENTRIES];
  logic [AVG_W-1:0]     meter_tx_avg  [CLIENT_ENTRIES];
  logic [GAIN_W-1:0]    model_gain;
  logic [RATE_W-1:0]    model_max_rate;

  logic [TOTAL_W-1:0]   feed_rx [CLIENT_ENTRIES];
  logic [TOTAL_W-1:0]   feed_tx [CLIENT_ENTRIES];

  meter_cmd_t     cmd_queue[$];
  meter_reading_t reading_expect[$];
  meter_cmd_t     drive_cmd;
  meter_cmd_t     seen_cmd;
  meter_reading_t want;

  logic word_taken     = 1'b0;
  logic word_pending   = 1'b0;
  logic hold_for_drain = 1'b0;
  logic activity;
  int   burst_left     = 1;
  int   gap_left       = 0;
  int   burst_count    = 0;
  int   idle_cycles    = 0;
  int   mismatch_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] sample_rate(logic [TOTAL_W-1:0] now, logic [TOTAL_W-1:0] last,
                                              logic [INTERVAL_W-1:0] ival);
    logic [63:0] cap, delta, div, quo, rem, v;
    cap   = {24'd0, model_max_rate, 8'd0};
    delta = (now > last) ? {1'b0, now - last} : 64'd0;
    div   = (ival < MIN_INTERVAL) ? {32'd0, MIN_INTERVAL} : {32'd0, ival};
    quo   = delta / div;
    rem   = delta % div;
    if (quo >= 64'h100_0000) begin
      return cap;
    end
    v = quo * 64'd256000 + (rem * 64'd256000) / div;
    return (v > cap) ? cap : v;
  endfunction

  function automatic logic [AVG_W-1:0] blend_average(logic [AVG_W-1:0] avg, logic [63:0] inst);
    logic [63:0] g, a, s;
    g = (model_gain > GAIN_ONE) ? {47'd0, GAIN_ONE} : {47'd0, model_gain};
    a = {24'd0, avg};
    s = a * (64'h10000 - g) + inst * g + 64'd32768;
    return s[AVG_W+15:16];
  endfunction

  function automatic meter_reading_t predict_meter(meter_cmd_t c);
    meter_reading_t r;
    int e;
    e = c.client;
    r.known = meter_valid[e];
    if (c.op == OP_RELEASE) begin
      meter_valid[e]   = 1'b0;
      meter_last_rx[e] = '0;
      meter_last_tx[e] = '0;
      meter_rx_avg[e]  = '0;
      meter_tx_avg[e]  = '0;
    end else if (c.interval_ms != '0) begin
      if (r.known) begin
        meter_rx_avg[e] = blend_average(meter_rx_avg[e],
                                        sample_rate(c.rx_total, meter_last_rx[e], c.interval_ms));
        meter_tx_avg[e] = blend_average(meter_tx_avg[e],
                                        sample_rate(c.tx_total, meter_last_tx[e], c.interval_ms));
      end
      meter_last_rx[e] = c.rx_total;
      meter_last_tx[e] = c.tx_total;
      meter_valid[e]   = 1'b1;
    end
    r.rx_avg = meter_rx_avg[e];
    r.tx_avg = meter_tx_avg[e];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [AVG_W-1:0] got, logic [AVG_W-1:0] exp_val);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("%0t ns: %s got %0h, expected %0h", $time, what, got, exp_val);
    end
  endtask

  task automatic queue_cmd(logic op, int client, logic [TOTAL_W-1:0] rx, logic [TOTAL_W-1:0] tx,
                           logic [INTERVAL_W-1:0] ival);
    meter_cmd_t c;
    c.op          = op;
    c.client      = client;
    c.rx_total    = rx;
    c.tx_total    = tx;
    c.interval_ms = ival;
    cmd_queue.push_back(c);
  endtask

  function automatic logic [TOTAL_W-1:0] next_total(logic [TOTAL_W-1:0] last);
    logic [63:0] wide;
    int pick;
    pick = $urandom_range(0, 19);
    wide = {$urandom, $urandom};
    if (pick == 0) begin
      return wide[TOTAL_W-1:0];
    end else if (pick == 1) begin
      return last - $urandom_range(1, 100000);
    end else if (pick == 2) begin
      return last + (wide >> $urandom_range(20, 50));
    end
    return last + $urandom_range(0, 300000000);
  endfunction

  task automatic queue_random_words(int count);
    int k, c, pick;
    logic [INTERVAL_W-1:0] ival;
    for (k = 0; k < count; k++) begin
      c    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, CLIENT_ENTRIES - 1)
                                         : $urandom_range(0, 7);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        ival = '0;
      end else if (pick == 1) begin
        ival = $urandom;
      end else if (pick == 2) begin
        ival = $urandom_range(1, 999);
      end else begin
        ival = $urandom_range(200, 6000);
      end
      if ($urandom_range(0, 99) < 6) begin
        queue_cmd(OP_RELEASE, c, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      end else begin
        feed_rx[c] = next_total(feed_rx[c]);
        feed_tx[c] = next_total(feed_tx[c]);
        queue_cmd(OP_UPDATE, c, feed_rx[c], feed_tx[c], ival);
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (cmd_queue.size() != 0 || word_pending || reading_expect.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_SMOOTHING_GAIN) begin
      model_gain = data[GAIN_W-1:0];
    end else begin
      model_max_rate = data;
    end
  endtask

  always @(negedge clk_i) begin
    if (word_taken) begin
      word_taken   = 1'b0;
      word_pending = 1'b0;
    end
    if (!word_pending) begin
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (cmd_queue.size() != 0 && !(hold_for_drain && reading_expect.size() != 0)) begin
        drive_cmd      = cmd_queue.pop_front();
        op_i           <= drive_cmd.op;
        client_index_i <= drive_cmd.client;
        rx_total_i     <= drive_cmd.rx_total;
        tx_total_i     <= drive_cmd.tx_total;
        interval_ms_i  <= drive_cmd.interval_ms;
        start_i        <= 1'b1;
        word_pending   = 1'b1;
        hold_for_drain = 1'b0;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) == 0) begin
            gap_left = 0;
          end else if ($urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(17, 80);
          end else begin
            gap_left = $urandom_range(1, 16);
          end
          burst_count++;
          hold_for_drain = (burst_count % 7 == 0);
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      activity = 1'b0;
      if (done_o) begin
        activity = 1'b1;
        if (reading_expect.size() == 0) begin
          report_mismatch("unexpected result", avg_rx_rate_o, '0);
        end else begin
          want = reading_expect.pop_front();
          if (avg_rx_rate_o !== want.rx_avg) begin
            report_mismatch("avg_rx_rate", avg_rx_rate_o, want.rx_avg);
          end
          if (avg_tx_rate_o !== want.tx_avg) begin
            report_mismatch("avg_tx_rate", avg_tx_rate_o, want.tx_avg);
          end
          if (entry_known_o !== want.known) begin
            report_mismatch("entry_known", {39'd0, entry_known_o}, {39'd0, want.known});
          end
        end
      end
      if (start_i && !busy_o) begin
        activity             = 1'b1;
        seen_cmd.op          = op_i;
        seen_cmd.client      = client_index_i;
        seen_cmd.rx_total    = rx_total_i;
        seen_cmd.tx_total    = tx_total_i;
        seen_cmd.interval_ms = interval_ms_i;
        reading_expect.push_back(predict_meter(seen_cmd));
        word_taken = 1'b1;
      end
      idle_cycles = activity ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    for (int e = 0; e < CLIENT_ENTRIES; e++) begin
      meter_valid[e]   = 1'b0;
      meter_last_rx[e] = '0;
      meter_last_tx[e] = '0;
      meter_rx_avg[e]  = '0;
      meter_tx_avg[e]  = '0;
      feed_rx[e]       = '0;
      feed_tx[e]       = '0;
    end
    model_gain     = GAIN_RESET;
    model_max_rate = MAX_RATE_RESET;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    queue_cmd(OP_UPDATE,  0, 63'd5, 63'd5, 32'd0);
    queue_cmd(OP_RELEASE, 1, TOTAL_MAX, TOTAL_MAX, 32'hFFFF_FFFF);
    queue_cmd(OP_UPDATE,  0, 63'd0, 63'd0, 32'd1000);
    queue_cmd(OP_UPDATE,  0, 63'd1000000, 63'd2000000, 32'd1000);
    queue_cmd(OP_UPDATE,  0, TOTAL_MAX, TOTAL_MAX, 32'd1);
    queue_cmd(OP_UPDATE,  0, 63'd0, 63'd0, 32'd2000);
    queue_cmd(OP_UPDATE,  0, 63'd250000000, 63'd12345, 32'hFFFF_FFFF);
    queue_cmd(OP_UPDATE,  0, 63'd900000000, 63'd900000000, 32'd0);
    queue_cmd(OP_UPDATE,  0, 63'd250000999, 63'd50000000, 32'd999);
    queue_cmd(OP_RELEASE, 0, 63'd0, 63'd0, 32'd0);
    queue_cmd(OP_UPDATE,  0, 63'd1000000000, 63'd1000000000, 32'd1500);
    queue_cmd(OP_UPDATE,  0, 63'd1130000000, 63'd1124999999, 32'd1000);
    queue_cmd(OP_UPDATE, 63, {21{3'b010}}, {21{3'b101}}, 32'hAAAA_AAAA);
    queue_cmd(OP_UPDATE, 63, {21{3'b101}}, {21{3'b010}}, 32'h5555_5555);
    queue_cmd(OP_UPDATE, 42, TOTAL_MAX, 63'd0, 32'd1000);
    queue_cmd(OP_UPDATE, 42, 63'd0, TOTAL_MAX, 32'd1000);
    queue_cmd(OP_RELEASE, 63, 63'd0, 63'd0, 32'd0);
    queue_cmd(OP_RELEASE, 63, 63'd0, 63'd0, 32'd0);
    queue_cmd(OP_UPDATE, 21, 63'd77, 63'd88, 32'd1);
    queue_cmd(OP_UPDATE, 21, 63'd125000077, 63'd125000088, 32'd1);
    wait_idle();

    write_register(CFG_SMOOTHING_GAIN, GAIN_ONE);
    write_register(CFG_MAX_RATE, 32'hFFFF_FFFF);
    queue_cmd(OP_UPDATE, 42, TOTAL_MAX, TOTAL_MAX, 32'd1000);
    queue_random_words(RANDOM_WORDS);
    wait_idle();

    write_register(CFG_SMOOTHING_GAIN, 32'd0);
    write_register(CFG_MAX_RATE, 32'd0);
    queue_random_words(RANDOM_WORDS);
    wait_idle();

    write_register(CFG_SMOOTHING_GAIN, 32'h1_FFFF);
    write_register(CFG_MAX_RATE, $urandom);
    queue_random_words(RANDOM_WORDS);
    wait_idle();

    write_register(CFG_SMOOTHING_GAIN, $urandom_range(0, 65536));
    write_register(CFG_MAX_RATE, $urandom_range(1000, 200000000));
    queue_random_words(RANDOM_WORDS);
    wait_idle();

    write_register(CFG_SMOOTHING_GAIN, GAIN_RESET);
    write_register(CFG_MAX_RATE, MAX_RATE_RESET);
    queue_random_words(RANDOM_WORDS);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
